FILE: rtl/vpa_pkg.sv
// Shared constants and codes for the variable partition allocator.
`timescale 1ns / 1ps
package vpa_pkg;

  localparam int unsigned MaxProcsDef = 16;
  localparam int unsigned MaxFreeDef  = 17;
  localparam int unsigned AddrBitsDef = 16;

  localparam logic [15:0] MemSizeRst  = 16'd1024;
  localparam logic [15:0] MinSliceRst = 16'd10;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_MEMSIZE  = 2'd0;
  localparam logic [1:0] CFG_POLICY   = 2'd1;
  localparam logic [1:0] CFG_MINSLICE = 2'd2;

  // fit policies; the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_SPARE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

FILE: rtl/vpa_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module vpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/variable_partition_allocator.sv
// Top level of the variable partition allocator: sequencer over two table RAMs.
//
//  channel   signals                                          direction
//  --------  -----------------------------------------------  ---------
//  request   start, opcode_i, request_size_i,                  in
//            process_id_i (busy is out)
//  result    done_o, status_o, granted_id_o, start_address_o,  out
//            granted_size_o
//  config    cfg_valid_i, cfg_index_i, cfg_data_i;  in (cfg_ready_o out)
//
// Sequencing: one request at a time, every table access goes through a RAM port.
//   allocate: a free table scan, then an owned table scan per candidate
//   id tried (usually one); bad size or full table answer at once.
//   free: an owned table lookup of the id, then a free table merge scan.
// Reset clears the valid bits but that of free entry zero, which is seeded from
//   the memory size register, so no clearing pass is needed.
// done_o is a single-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
module variable_partition_allocator #(
  parameter int unsigned MAX_PROCS = vpa_pkg::MaxProcsDef,
  parameter int unsigned MAX_FREE  = vpa_pkg::MaxFreeDef,
  parameter int unsigned ADDR_BITS = vpa_pkg::AddrBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [15:0] request_size_i,
  input  logic [7:0]  process_id_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  granted_id_o,
  output logic [15:0] start_address_o,
  output logic [15:0] granted_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import vpa_pkg::*;

  localparam int unsigned AB  = ADDR_BITS;
  localparam int unsigned CW  = (AB > 16) ? AB : 16;
  localparam int unsigned FW  = 2 * AB;
  localparam int unsigned OW  = 8 + 2 * AB;
  localparam int unsigned FI  = $clog2(MAX_FREE);
  localparam int unsigned PI  = $clog2(MAX_PROCS);
  localparam int unsigned SCW = $clog2(((MAX_FREE > MAX_PROCS) ? MAX_FREE : MAX_PROCS) + 1);
  localparam logic [CW-1:0]  AddrMaskX = CW'({AB{1'b1}});
  localparam logic [SCW-1:0] FreeLast  = SCW'(MAX_FREE - 1);
  localparam logic [SCW-1:0] ProcLast  = SCW'(MAX_PROCS - 1);
  localparam logic [SCW-1:0] FreeLim   = SCW'(MAX_FREE);
  localparam logic [SCW-1:0] ProcLim   = SCW'(MAX_PROCS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AFSCAN = 3'd1;  // free table scan for a fit
  localparam logic [2:0] S_AIDCHK = 3'd2;  // step past id zero
  localparam logic [2:0] S_AIDSCN = 3'd3;  // owned table scan for id clash
  localparam logic [2:0] S_FOSCAN = 3'd4;  // owned table lookup of the id
  localparam logic [2:0] S_FMSCAN = 3'd5;  // free table scan for neighbors

  logic [2:0] state_q, state_d;

  // configuration
  logic [15:0] memsz_q, memsz_d;
  logic [1:0]  policy_q, policy_d;
  logic [15:0] minsl_q, minsl_d;

  // table valid bits and the seed flag for free entry zero
  logic [MAX_FREE-1:0]  fvalid_q, fvalid_d;
  logic [MAX_PROCS-1:0] ovalid_q, ovalid_d;
  logic                 seed_q, seed_d;
  logic [7:0]           last_id_q, last_id_d;

  // scan control
  logic [SCW-1:0] sc_q, sc_d, ev_q, ev_d;
  logic           rv_q, rv_d;

  // request
  logic [15:0] size_q, size_d;
  logic [7:0]  pid_q, pid_d;
  logic [PI-1:0] slot_q, slot_d;

  // allocate working registers
  logic          pickv_q, pickv_d;
  logic [FI-1:0] pidx_q, pidx_d;
  logic [AB-1:0] pstart_q, pstart_d, plen_q, plen_d;
  logic [AB-1:0] gstart_q, gstart_d, glen_q, glen_d;
  logic [7:0]    cand_q, cand_d;
  logic          hit_q, hit_d;

  // free working registers
  logic          found_q, found_d;
  logic [PI-1:0] own_q, own_d;
  logic [AB-1:0] ostart_q, ostart_d, olen_q, olen_d;
  logic          lf_q, lf_d, rf_q, rf_d;
  logic [FI-1:0] lidx_q, lidx_d, ridx_q, ridx_d;
  logic [AB-1:0] lstart_q, lstart_d, llen_q, llen_d, rlen_q, rlen_d;

  // result
  logic        done_q, done_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  gid_q, gid_d;
  logic [15:0] saddr_q, saddr_d, gsize_q, gsize_d;

  // RAM ports
  logic          fwe, owe;
  logic [FI-1:0] fwaddr;
  logic [PI-1:0] owaddr;
  logic [FW-1:0] fwdata, frdata;
  logic [OW-1:0] owdata, ordata;

  vpa_ram #(.Width(FW), .Depth(MAX_FREE)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (fwaddr),
    .wdata_i (fwdata),
    .raddr_i (sc_q[FI-1:0]),
    .rdata_o (frdata)
  );

  vpa_ram #(.Width(OW), .Depth(MAX_PROCS)) u_owned_ram (
    .clk_i   (clk_i),
    .we_i    (owe),
    .waddr_i (owaddr),
    .wdata_i (owdata),
    .raddr_i (sc_q[PI-1:0]),
    .rdata_o (ordata)
  );

  // seed length saturates to the address range
  logic [CW-1:0] memsz_x;
  logic [AB-1:0] seed_len;
  assign memsz_x  = CW'(memsz_q);
  assign seed_len = AB'((memsz_x > AddrMaskX) ? AddrMaskX : memsz_x);

  // decoded read data of the entry under evaluation
  logic          seed_hit, f_val, o_val;
  logic [AB-1:0] f_start, f_len, o_start, o_len;
  logic [7:0]    o_id;
  assign seed_hit = seed_q && (ev_q == '0);
  assign f_start  = seed_hit ? '0 : frdata[FW-1:AB];
  assign f_len    = seed_hit ? seed_len : frdata[AB-1:0];
  assign f_val    = rv_q && fvalid_q[ev_q[FI-1:0]];
  assign o_id     = ordata[OW-1:FW];
  assign o_start  = ordata[FW-1:AB];
  assign o_len    = ordata[AB-1:0];
  assign o_val    = rv_q && ovalid_q[ev_q[PI-1:0]];

  // lowest free slots from the valid bits
  logic          oslot_ok, fslot_ok;
  logic [PI-1:0] oslot;
  logic [FI-1:0] fslot;
  always_comb begin
    oslot_ok = 1'b0;
    oslot    = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (!ovalid_q[i]) begin
        oslot_ok = 1'b1;
        oslot    = PI'(i);
      end
    end
    fslot_ok = 1'b0;
    fslot    = '0;
    for (int i = MAX_FREE - 1; i >= 0; i--) begin
      if (!fvalid_q[i]) begin
        fslot_ok = 1'b1;
        fslot    = FI'(i);
      end
    end
  end

  // fit choice for the current entry
  logic          fits, better, take;
  logic          npv;
  logic [FI-1:0] nidx;
  logic [AB-1:0] nstart, nlen;
  always_comb begin
    fits = f_val && (CW'(f_len) >= CW'(size_q));
    unique case (policy_q)
      POL_BEST:  better = (f_len < plen_q) || ((f_len == plen_q) && (f_start < pstart_q));
      POL_WORST: better = (f_len > plen_q) || ((f_len == plen_q) && (f_start < pstart_q));
      default:   better = f_start < pstart_q;
    endcase
    take   = fits && (!pickv_q || better);
    npv    = pickv_q || take;
    nidx   = take ? ev_q[FI-1:0] : pidx_q;
    nstart = take ? f_start : pstart_q;
    nlen   = take ? f_len : plen_q;
  end

  // neighbor match for the extent being freed
  logic [AB:0]   oend, fend;
  logic          ml, mr, nlf, nrf;
  logic [FI-1:0] nlidx, nridx;
  logic [AB-1:0] nlstart, nllen, nrlen;
  always_comb begin
    oend    = {1'b0, ostart_q} + {1'b0, olen_q};
    fend    = {1'b0, f_start} + {1'b0, f_len};
    ml      = f_val && !lf_q && (fend == {1'b0, ostart_q});
    mr      = f_val && !rf_q && ({1'b0, f_start} == oend);
    nlf     = lf_q || ml;
    nrf     = rf_q || mr;
    nlidx   = ml ? ev_q[FI-1:0] : lidx_q;
    nlstart = ml ? f_start : lstart_q;
    nllen   = ml ? f_len : llen_q;
    nridx   = mr ? ev_q[FI-1:0] : ridx_q;
    nrlen   = mr ? f_len : rlen_q;
  end

  logic [CW-1:0] leftover;
  logic          idm, ownm;
  assign leftover = CW'(nlen) - CW'(size_q);
  assign idm      = o_val && (o_id == cand_q);
  assign ownm     = o_val && !found_q && (o_id == pid_q);

  always_comb begin
    state_d   = state_q;
    memsz_d   = memsz_q;
    policy_d  = policy_q;
    minsl_d   = minsl_q;
    fvalid_d  = fvalid_q;
    ovalid_d  = ovalid_q;
    seed_d    = seed_q;
    last_id_d = last_id_q;
    sc_d      = sc_q;
    ev_d      = sc_q;
    rv_d      = 1'b0;
    size_d    = size_q;
    pid_d     = pid_q;
    slot_d    = slot_q;
    pickv_d   = pickv_q;
    pidx_d    = pidx_q;
    pstart_d  = pstart_q;
    plen_d    = plen_q;
    gstart_d  = gstart_q;
    glen_d    = glen_q;
    cand_d    = cand_q;
    hit_d     = hit_q;
    found_d   = found_q;
    own_d     = own_q;
    ostart_d  = ostart_q;
    olen_d    = olen_q;
    lf_d      = lf_q;
    rf_d      = rf_q;
    lidx_d    = lidx_q;
    ridx_d    = ridx_q;
    lstart_d  = lstart_q;
    llen_d    = llen_q;
    rlen_d    = rlen_q;
    done_d    = 1'b0;
    status_d  = status_q;
    gid_d     = gid_q;
    saddr_d   = saddr_q;
    gsize_d   = gsize_q;
    fwe       = 1'b0;
    fwaddr    = '0;
    fwdata    = '0;
    owe       = 1'b0;
    owaddr    = slot_q;
    owdata    = {cand_q, gstart_q, glen_q};

    unique case (state_q)
      S_IDLE: begin
        sc_d = '0;
        if (start) begin
          size_d  = request_size_i;
          pid_d   = process_id_i;
          found_d = 1'b0;
          pickv_d = 1'b0;
          slot_d  = oslot;
          if (opcode_i == OP_FREE) begin
            state_d = S_FOSCAN;
          end else if (request_size_i == '0) begin
            done_d   = 1'b1;
            status_d = ST_BADSIZE;
            gid_d    = '0;
            saddr_d  = '0;
            gsize_d  = '0;
          end else if (!oslot_ok) begin
            done_d   = 1'b1;
            status_d = ST_FULL;
            gid_d    = '0;
            saddr_d  = '0;
            gsize_d  = '0;
          end else begin
            state_d = S_AFSCAN;
          end
        end
      end

      S_AFSCAN: begin
        rv_d    = sc_q != FreeLim;
        sc_d    = rv_d ? sc_q + 1'b1 : sc_q;
        pickv_d = npv;
        pidx_d  = nidx;
        pstart_d = nstart;
        plen_d  = nlen;
        if (rv_q && ev_q == FreeLast) begin
          rv_d = 1'b0;
          if (!npv) begin
            done_d   = 1'b1;
            status_d = ST_NOFIT;
            gid_d    = '0;
            saddr_d  = '0;
            gsize_d  = '0;
            state_d  = S_IDLE;
          end else begin
            gstart_d = nstart;
            if (leftover <= CW'(minsl_q)) begin
              fvalid_d[nidx] = 1'b0;
              glen_d         = nlen;
            end else begin
              fwe    = 1'b1;
              fwaddr = nidx;
              fwdata = {nstart + AB'(size_q), AB'(leftover)};
              glen_d = AB'(size_q);
            end
            cand_d  = last_id_q + 8'd1;
            state_d = S_AIDCHK;
          end
        end
      end

      S_AIDCHK: begin
        sc_d  = '0;
        hit_d = 1'b0;
        if (cand_q == '0) begin
          cand_d = 8'd1;
        end else begin
          state_d = S_AIDSCN;
        end
      end

      S_AIDSCN: begin
        rv_d  = sc_q != ProcLim;
        sc_d  = rv_d ? sc_q + 1'b1 : sc_q;
        hit_d = hit_q || idm;
        if (rv_q && ev_q == ProcLast) begin
          rv_d = 1'b0;
          if (hit_q || idm) begin
            cand_d  = cand_q + 8'd1;
            state_d = S_AIDCHK;
          end else begin
            owe              = 1'b1;
            ovalid_d[slot_q] = 1'b1;
            last_id_d        = cand_q;
            done_d           = 1'b1;
            status_d         = ST_OK;
            gid_d            = cand_q;
            saddr_d          = 16'(gstart_q);
            gsize_d          = 16'(glen_q);
            state_d          = S_IDLE;
          end
        end
      end

      S_FOSCAN: begin
        rv_d = sc_q != ProcLim;
        sc_d = rv_d ? sc_q + 1'b1 : sc_q;
        if (ownm) begin
          found_d  = 1'b1;
          own_d    = ev_q[PI-1:0];
          ostart_d = o_start;
          olen_d   = o_len;
        end
        if (rv_q && ev_q == ProcLast) begin
          rv_d = 1'b0;
          sc_d = '0;
          lf_d = 1'b0;
          rf_d = 1'b0;
          if (!(found_q || ownm)) begin
            done_d   = 1'b1;
            status_d = ST_UNKNOWN;
            gid_d    = '0;
            saddr_d  = '0;
            gsize_d  = '0;
            state_d  = S_IDLE;
          end else begin
            state_d = S_FMSCAN;
          end
        end
      end

      S_FMSCAN: begin
        rv_d     = sc_q != FreeLim;
        sc_d     = rv_d ? sc_q + 1'b1 : sc_q;
        lf_d     = nlf;
        rf_d     = nrf;
        lidx_d   = nlidx;
        ridx_d   = nridx;
        lstart_d = nlstart;
        llen_d   = nllen;
        rlen_d   = nrlen;
        if (rv_q && ev_q == FreeLast) begin
          rv_d    = 1'b0;
          state_d = S_IDLE;
          done_d  = 1'b1;
          gid_d   = '0;
          if (!nlf && !nrf && !fslot_ok) begin
            status_d = ST_FULL;
            saddr_d  = '0;
            gsize_d  = '0;
          end else begin
            fwe = 1'b1;
            priority if (nlf && nrf) begin
              fwaddr          = nlidx;
              fwdata          = {nlstart, nllen + olen_q + nrlen};
              fvalid_d[nridx] = 1'b0;
            end else if (nlf) begin
              fwaddr = nlidx;
              fwdata = {nlstart, nllen + olen_q};
            end else if (nrf) begin
              fwaddr = nridx;
              fwdata = {ostart_q, nrlen + olen_q};
            end else begin
              fwaddr          = fslot;
              fwdata          = {ostart_q, olen_q};
              fvalid_d[fslot] = 1'b1;
            end
            ovalid_d[own_q] = 1'b0;
            status_d        = ST_OK;
            saddr_d         = 16'(ostart_q);
            gsize_d         = 16'(olen_q);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a real write to entry zero replaces the seeded contents
    if (fwe && fwaddr == '0) begin
      seed_d = 1'b0;
    end

    // configuration writes must arrive only while the block is idle; the block itself does not enforce this
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MEMSIZE: begin
          memsz_d     = cfg_data_i;
          fvalid_d    = '0;
          fvalid_d[0] = cfg_data_i != '0;
          ovalid_d    = '0;
          seed_d      = 1'b1;
          last_id_d   = '0;
        end
        CFG_POLICY:   policy_d = cfg_data_i[1:0];
        CFG_MINSLICE: minsl_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      memsz_q   <= MemSizeRst;
      policy_q  <= POL_FIRST;
      minsl_q   <= MinSliceRst;
      fvalid_q  <= MAX_FREE'(1);
      ovalid_q  <= '0;
      seed_q    <= 1'b1;
      last_id_q <= '0;
      sc_q      <= '0;
      ev_q      <= '0;
      rv_q      <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      memsz_q   <= memsz_d;
      policy_q  <= policy_d;
      minsl_q   <= minsl_d;
      fvalid_q  <= fvalid_d;
      ovalid_q  <= ovalid_d;
      seed_q    <= seed_d;
      last_id_q <= last_id_d;
      sc_q      <= sc_d;
      ev_q      <= ev_d;
      rv_q      <= rv_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    pid_q    <= pid_d;
    slot_q   <= slot_d;
    pickv_q  <= pickv_d;
    pidx_q   <= pidx_d;
    pstart_q <= pstart_d;
    plen_q   <= plen_d;
    gstart_q <= gstart_d;
    glen_q   <= glen_d;
    cand_q   <= cand_d;
    hit_q    <= hit_d;
    found_q  <= found_d;
    own_q    <= own_d;
    ostart_q <= ostart_d;
    olen_q   <= olen_d;
    lf_q     <= lf_d;
    rf_q     <= rf_d;
    lidx_q   <= lidx_d;
    ridx_q   <= ridx_d;
    lstart_q <= lstart_d;
    llen_q   <= llen_d;
    rlen_q   <= rlen_d;
    status_q <= status_d;
    gid_q    <= gid_d;
    saddr_q  <= saddr_d;
    gsize_q  <= gsize_d;
  end

  assign busy            = state_q != S_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_id_o    = gid_q;
  assign start_address_o = saddr_q;
  assign granted_size_o  = gsize_q;

endmodule

FILE: rtl/vpa_checker.sv
// Port-level assertions for the variable partition allocator, with bind.
`timescale 1ns / 1ps
module vpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [7:0]  granted_id_o,
  input logic [15:0] start_address_o,
  input logic [15:0] granted_size_o
);
  import vpa_pkg::*;

  // a failed request reports an empty extent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |->
      granted_id_o == '0 && start_address_o == '0 && granted_size_o == '0)
    else $error("failed request with nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == ST_OK || status_o == ST_NOFIT || status_o == ST_BADSIZE ||
               status_o == ST_FULL || status_o == ST_UNKNOWN)
    else $error("status code out of range");

  // a granted id always comes with a nonempty extent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_OK && granted_id_o != '0 |-> granted_size_o != '0)
    else $error("granted id with empty extent");

  // the result beat closes the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while still busy");

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .granted_id_o    (granted_id_o),
  .start_address_o (start_address_o),
  .granted_size_o  (granted_size_o)
);
